// ===== hdl/seg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_pkg
// Shared types and constants of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package seg_pkg;

  // Fraction bits of the Q12.4 coordinates; a miss reports -1.0.
  localparam int FRAC_BITS = 4;

  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/seg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_front
// Differences, cross products, range tests and the divider numerators.
// ----------------------------------------------------------------------------
module seg_front import seg_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic                      clk,
  input  wire logic [4:0]                en,
  input  wire logic signed [W-1:0]       ax,
  input  wire logic signed [W-1:0]       ay,
  input  wire logic signed [W-1:0]       bx,
  input  wire logic signed [W-1:0]       by,
  input  wire logic signed [W-1:0]       cx,
  input  wire logic signed [W-1:0]       cy,
  input  wire logic signed [W-1:0]       dx,
  input  wire logic signed [W-1:0]       dy,
  output logic [3*W+2:0]                 num_x,
  output logic [3*W+2:0]                 num_y,
  output logic [2*W+2:0]                 den_mag,
  output pipe_ctl_t                      ctl,
  output logic [W-1:0]                   ax_out,
  output logic [W-1:0]                   ay_out
);

  localparam int D = W + 1;
  localparam int C = 2 * D + 1;

  logic signed [D-1:0] abx1, aby1, cdx1, cdy1, acx1, acy1;
  logic signed [W-1:0] ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4;
  logic signed [D-1:0] abx2, aby2, abx3, aby3;
  logic signed [2*D-1:0] p_den0, p_den1, p_tn0, p_tn1, p_sn0, p_sn1;
  logic signed [C-1:0] den3, tn3, sn3;
  logic [C-1:0] dmag_c, tmag_c, smag_c;
  logic [C-1:0] dmag4, tmag4;
  logic [W-1:0] sx_c, sy_c, sx4, sy4;
  logic t_ok, s_ok;
  pipe_ctl_t ctl_c, ctl4;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      abx1 <= D'(bx) - D'(ax);
      aby1 <= D'(by) - D'(ay);
      cdx1 <= D'(dx) - D'(cx);
      cdy1 <= D'(dy) - D'(cy);
      acx1 <= D'(cx) - D'(ax);
      acy1 <= D'(cy) - D'(ay);
      ax1  <= ax;
      ay1  <= ay;
    end
    if (en[1]) begin
      p_den0 <= aby1 * cdx1;
      p_den1 <= abx1 * cdy1;
      p_tn0  <= acy1 * cdx1;
      p_tn1  <= acx1 * cdy1;
      p_sn0  <= acy1 * abx1;
      p_sn1  <= acx1 * aby1;
      abx2   <= abx1;
      aby2   <= aby1;
      ax2    <= ax1;
      ay2    <= ay1;
    end
    if (en[2]) begin
      den3 <= C'(p_den0) - C'(p_den1);
      tn3  <= C'(p_tn0) - C'(p_tn1);
      sn3  <= C'(p_sn0) - C'(p_sn1);
      abx3 <= abx2;
      aby3 <= aby2;
      ax3  <= ax2;
      ay3  <= ay2;
    end
    if (en[3]) begin
      dmag4 <= dmag_c;
      tmag4 <= tmag_c;
      sx4   <= sx_c;
      sy4   <= sy_c;
      ctl4  <= ctl_c;
      ax4   <= ax3;
      ay4   <= ay3;
    end
    if (en[4]) begin
      num_x   <= (3*W+3)'(tmag4) * (3*W+3)'(sx4);
      num_y   <= (3*W+3)'(tmag4) * (3*W+3)'(sy4);
      den_mag <= dmag4;
      ctl     <= ctl4;
      ax_out  <= ax4;
      ay_out  <= ay4;
    end
  end

  always_comb begin
    dmag_c = den3[C-1] ? C'(-den3) : C'(den3);
    tmag_c = tn3[C-1] ? C'(-tn3) : C'(tn3);
    smag_c = sn3[C-1] ? C'(-sn3) : C'(sn3);
    sx_c   = abx3[D-1] ? W'(-abx3) : W'(abx3);
    sy_c   = aby3[D-1] ? W'(-aby3) : W'(aby3);
    t_ok   = (tn3 == '0) || ((tn3[C-1] == den3[C-1]) && (tmag_c <= dmag_c));
    s_ok   = (sn3 == '0) || ((sn3[C-1] == den3[C-1]) && (smag_c <= dmag_c));
    ctl_c.hit   = (den3 != '0) && t_ok && s_ok;
    ctl_c.neg_x = (tn3[C-1] != den3[C-1]) ? !abx3[D-1] : abx3[D-1];
    ctl_c.neg_y = (tn3[C-1] != den3[C-1]) ? !aby3[D-1] : aby3[D-1];
  end

endmodule
`default_nettype wire

// ===== hdl/seg_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_div_step
// One restoring division stage for both coordinates, resolving quotient bit B.
// ----------------------------------------------------------------------------
module seg_div_step import seg_pkg::*; #(
  parameter int W = 16,
  parameter int B = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [3*W+2:0]    rem_x_in,
  input  wire logic [3*W+2:0]    rem_y_in,
  input  wire logic [W-1:0]      q_x_in,
  input  wire logic [W-1:0]      q_y_in,
  input  wire logic [2*W+2:0]    den_in,
  input  wire pipe_ctl_t         ctl_in,
  input  wire logic [W-1:0]      ax_in,
  input  wire logic [W-1:0]      ay_in,
  output logic [3*W+2:0]         rem_x,
  output logic [3*W+2:0]         rem_y,
  output logic [W-1:0]           q_x,
  output logic [W-1:0]           q_y,
  output logic [2*W+2:0]         den,
  output pipe_ctl_t              ctl,
  output logic [W-1:0]           ax,
  output logic [W-1:0]           ay
);

  localparam int NW = 3 * W + 3;

  logic [NW-1:0] dsh;
  logic [W-1:0]  qbit;

  assign dsh  = NW'(den_in) << B;
  assign qbit = W'(1) << B;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_x_in >= dsh) begin
        rem_x <= rem_x_in - dsh;
        q_x   <= q_x_in | qbit;
      end else begin
        rem_x <= rem_x_in;
        q_x   <= q_x_in;
      end
      if (rem_y_in >= dsh) begin
        rem_y <= rem_y_in - dsh;
        q_y   <= q_y_in | qbit;
      end else begin
        rem_y <= rem_y_in;
        q_y   <= q_y_in;
      end
      den <= den_in;
      ctl <= ctl_in;
      ax  <= ax_in;
      ay  <= ay_in;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/segment_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection
// Parametric intersection test of segments AB and CD with the hit point.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle; a full stage holds while the next one cannot accept.
// The divider takes one stage per quotient bit, COORD_BITS stages.
// Reset clears all valid bits; data registers are not reset.
module segment_intersection import seg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]  s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // px, py from the lowest bit up
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,
  // hit
  output logic                                     m_tuser
);

  localparam int W  = COORD_BITS;
  localparam int NW = 3 * W + 3;
  localparam int DW = 2 * W + 3;
  localparam int NS = W + 6;
  localparam int OW = ((2*W+7)/8)*8;
  localparam logic [W-1:0] MISS = {{(W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

  logic [NS-1:0] valid;
  logic [NS:0]   en;

  logic [NW-1:0] rem_x [W+1];
  logic [NW-1:0] rem_y [W+1];
  logic [W-1:0]  q_x   [W+1];
  logic [W-1:0]  q_y   [W+1];
  logic [DW-1:0] den   [W+1];
  pipe_ctl_t     ctl   [W+1];
  logic [W-1:0]  pax   [W+1];
  logic [W-1:0]  pay   [W+1];

  logic [W-1:0] px, py;
  logic         hit;

  always_comb begin
    en[NS] = m_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  seg_front #(.W(W)) u_front (
    .clk     (clk),
    .en      (en[4:0]),
    .ax      (s_tdata[0*W +: W]),
    .ay      (s_tdata[1*W +: W]),
    .bx      (s_tdata[2*W +: W]),
    .by      (s_tdata[3*W +: W]),
    .cx      (s_tdata[4*W +: W]),
    .cy      (s_tdata[5*W +: W]),
    .dx      (s_tdata[6*W +: W]),
    .dy      (s_tdata[7*W +: W]),
    .num_x   (rem_x[0]),
    .num_y   (rem_y[0]),
    .den_mag (den[0]),
    .ctl     (ctl[0]),
    .ax_out  (pax[0]),
    .ay_out  (pay[0])
  );

  assign q_x[0] = '0;
  assign q_y[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    seg_div_step #(.W(W), .B(W - 1 - i)) u_step (
      .clk      (clk),
      .en       (en[5+i]),
      .rem_x_in (rem_x[i]),
      .rem_y_in (rem_y[i]),
      .q_x_in   (q_x[i]),
      .q_y_in   (q_y[i]),
      .den_in   (den[i]),
      .ctl_in   (ctl[i]),
      .ax_in    (pax[i]),
      .ay_in    (pay[i]),
      .rem_x    (rem_x[i+1]),
      .rem_y    (rem_y[i+1]),
      .q_x      (q_x[i+1]),
      .q_y      (q_y[i+1]),
      .den      (den[i+1]),
      .ctl      (ctl[i+1]),
      .ax       (pax[i+1]),
      .ay       (pay[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      hit <= ctl[W].hit;
      if (ctl[W].hit) begin
        px <= ctl[W].neg_x ? pax[W] - q_x[W] : pax[W] + q_x[W];
        py <= ctl[W].neg_y ? pay[W] - q_y[W] : pay[W] + q_y[W];
      end else begin
        px <= MISS;
        py <= MISS;
      end
    end
  end

  assign m_tdata = OW'({py, px});
  assign m_tuser = hit;

endmodule
`default_nettype wire
